>>> rtl/core/cmed_pkg.sv
// Shared types for the closest-match edit distance block.
// Used by the front end, the queue and the DP engine; no dependencies.
`timescale 1ns / 1ps
package cmed_pkg;

    // One classified input item as it travels from the front end to the engine.
    typedef struct packed {
        logic       is_cand;
        logic [7:0] char_code;
        logic       has_char;
        logic       end_of_string;
        logic       end_of_list;
    } cmed_item_t;

    localparam logic [15:0] IndexMax  = 16'hFFFF;
    localparam logic [5:0]  DistMax   = 6'd63;

endpackage

>>> rtl/core/cmed_queue.sv
// Short FIFO between the input front end and the DP engine.
// Depends on cmed_pkg for the item type.
`timescale 1ns / 1ps
module cmed_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cmed_pkg::cmed_item_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output cmed_pkg::cmed_item_t pop_item
);
    import cmed_pkg::*;

    cmed_item_t  slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = slot_reg[rd_ptr_reg];

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ (push && !full);
        rd_ptr_next = rd_ptr_reg ^ (pop && !empty);
        count_next  = count_reg + {1'b0, push && !full} - {1'b0, pop && !empty};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots need no reset.
    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wr_ptr_reg] <= push_item;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> full) else $error("full queue lost an entry");
    a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
        empty && !push |=> empty) else $error("empty queue gained an entry");
`endif
endmodule

>>> rtl/core/cmed_front.sv
// Input front end: takes item transfers and pushes them into the queue.
// Depends on cmed_pkg for the item type.
`timescale 1ns / 1ps
module cmed_front (
    input  logic                 valid_in,
    output logic                 stall_in,
    input  logic                 operation,
    input  logic [7:0]           char_code,
    input  logic                 has_char,
    input  logic                 end_of_string,
    input  logic                 end_of_list,
    input  logic                 q_full,
    output logic                 q_push,
    output cmed_pkg::cmed_item_t q_item
);
    import cmed_pkg::*;

    // Classify the item; end of list only matters on candidate items.
    always_comb
    begin
        q_item.is_cand       = operation;
        q_item.char_code     = char_code;
        q_item.has_char      = has_char;
        q_item.end_of_string = end_of_string;
        q_item.end_of_list   = end_of_list && operation;
        stall_in             = q_full;
        q_push               = valid_in && !q_full;
    end
endmodule

>>> rtl/core/cmed_engine.sv
// DP engine: stores the target and walks one DP column per candidate character.
// Depends on cmed_pkg for the item type and output limits.
`timescale 1ns / 1ps
module cmed_engine #(
    parameter int MAX_LEN = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  cmed_pkg::cmed_item_t q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [15:0]          option_index,
    output logic [5:0]           distance,
    output logic [15:0]          best_index,
    output logic [5:0]           best_distance,
    output logic                 is_new_best,
    output logic                 truncated,
    output logic                 last
);
    import cmed_pkg::*;

    localparam int AW = $clog2(MAX_LEN + 1);
    localparam int TW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 2);
    localparam int DW = $clog2(2 * MAX_LEN + 2);
    localparam logic [LW-1:0] MaxLen = LW'(MAX_LEN);

    typedef enum logic [1:0] { S_IDLE, S_INIT, S_STEP, S_CLOSE } state_t;

    // Target and DP column memories; one read each per cycle.
    logic [7:0]    tgt_mem [MAX_LEN];
    logic [DW-1:0] col_mem [MAX_LEN + 1];

    state_t        state_reg;
    cmed_item_t    item_reg;
    logic [LW-1:0] tlen_reg;
    logic          tclosed_reg, tovf_reg;
    logic [LW-1:0] clen_reg;
    logic          covf_reg, copen_reg;
    logic [15:0]   ccount_reg, bidx_reg;
    logic [DW-1:0] bdist_reg;
    logic          bvalid_reg;
    logic [AW-1:0] row_reg;
    logic [DW-1:0] diag_reg, up_reg;
    logic [7:0]    tch_rd_reg;
    logic [DW-1:0] col_rd_reg;
    logic          rd_ok_reg;
    logic          do_step_reg;

    logic          out_full;
    logic          res_fire;
    logic [AW-1:0] rd_row;
    logic [DW-1:0] cell_new;
    logic [DW-1:0] m1;

    assign out_full = out_valid && out_stall;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty && !out_full;
    assign res_fire = (state_reg == S_CLOSE) && !do_step_reg && rd_ok_reg && !out_full
                      && (item_reg.end_of_string || item_reg.end_of_list);

    function automatic logic [5:0] sat6(input logic [DW-1:0] v);
        if (DW > 6 && v > DW'(DistMax))
            return DistMax;
        return 6'(v);
    endfunction

    // One DP cell: diagonal on match, else one plus the smallest neighbor.
    always_comb
    begin
        m1 = (col_rd_reg < up_reg) ? col_rd_reg : up_reg;
        m1 = (m1 < diag_reg) ? m1 : diag_reg;
        cell_new = (tch_rd_reg == item_reg.char_code) ? diag_reg : m1 + DW'(1);
    end

    // Row whose cells are needed in the next cycle.
    always_comb
    begin
        if (state_reg == S_STEP && rd_ok_reg)
            rd_row = row_reg + AW'(1);
        else if (state_reg == S_CLOSE && !do_step_reg && !rd_ok_reg && tlen_reg != '0)
            rd_row = AW'(tlen_reg - LW'(1));
        else
            rd_row = row_reg;
    end

    // Memory reads for the next row, registered.
    always_ff @(posedge clk)
    begin
        tch_rd_reg <= tgt_mem[(rd_row < AW'(MAX_LEN)) ? TW'(rd_row) : TW'(0)];
        col_rd_reg <= col_mem[(rd_row < AW'(MAX_LEN)) ? rd_row + AW'(1) : AW'(0)];
    end

    // Memory writes.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_pop && !q_item.is_cand && q_item.has_char
            && !(tclosed_reg ? 1'b0 : (tlen_reg >= MaxLen)))
            tgt_mem[tclosed_reg ? TW'(0) : TW'(tlen_reg)] <= q_item.char_code;
        if (state_reg == S_INIT)
            col_mem[row_reg] <= DW'(row_reg);
        else if (state_reg == S_STEP && rd_ok_reg)
            col_mem[row_reg + AW'(1)] <= cell_new;
        else if (state_reg == S_STEP && !rd_ok_reg)
            col_mem[0] <= DW'(clen_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            tlen_reg    <= '0;
            tclosed_reg <= 1'b1;
            tovf_reg    <= 1'b0;
            clen_reg    <= '0;
            covf_reg    <= 1'b0;
            copen_reg   <= 1'b0;
            ccount_reg  <= '0;
            bidx_reg    <= '0;
            bdist_reg   <= '0;
            bvalid_reg  <= 1'b0;
            row_reg     <= '0;
            diag_reg    <= '0;
            up_reg      <= '0;
            rd_ok_reg   <= 1'b0;
            do_step_reg <= 1'b0;
            out_valid   <= 1'b0;
            item_reg    <= '0;
            option_index  <= '0;
            distance      <= '0;
            best_index    <= '0;
            best_distance <= '0;
            is_new_best   <= 1'b0;
            truncated     <= 1'b0;
            last          <= 1'b0;
        end
        else
        begin
            if (res_fire)
                out_valid <= 1'b1;
            else if (out_valid && !out_stall)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        item_reg <= q_item;
                        if (!q_item.is_cand)
                        begin
                            // Target item: a new target restarts everything.
                            if (tclosed_reg)
                            begin
                                tovf_reg   <= 1'b0;
                                copen_reg  <= 1'b0;
                                ccount_reg <= '0;
                                bidx_reg   <= '0;
                                bdist_reg  <= '0;
                                bvalid_reg <= 1'b0;
                                tlen_reg   <= q_item.has_char ? LW'(1) : '0;
                            end
                            else if (q_item.has_char)
                            begin
                                if (tlen_reg < MaxLen)
                                    tlen_reg <= tlen_reg + LW'(1);
                                else
                                    tovf_reg <= 1'b1;
                            end
                            tclosed_reg <= q_item.end_of_string;
                        end
                        else
                        begin
                            tclosed_reg <= 1'b1;
                            row_reg     <= '0;
                            do_step_reg <= q_item.has_char;
                            if (!copen_reg)
                            begin
                                clen_reg  <= '0;
                                covf_reg  <= 1'b0;
                                copen_reg <= 1'b1;
                                state_reg <= S_INIT;
                            end
                            else
                                state_reg <= S_CLOSE;
                        end
                    end
                end
                S_INIT:
                begin
                    // Column starts as 0..m.
                    if (row_reg[AW-1:0] == tlen_reg[AW-1:0])
                    begin
                        row_reg   <= '0;
                        state_reg <= S_CLOSE;
                    end
                    else
                        row_reg <= row_reg + AW'(1);
                end
                S_STEP:
                begin
                    if (!rd_ok_reg)
                    begin
                        // Row zero written; first read is in flight.
                        rd_ok_reg <= 1'b1;
                        up_reg    <= DW'(clen_reg);
                    end
                    else
                    begin
                        diag_reg <= col_rd_reg;
                        up_reg   <= cell_new;
                        if (LW'(row_reg) + LW'(1) >= tlen_reg)
                        begin
                            rd_ok_reg <= 1'b0;
                            state_reg <= S_CLOSE;
                        end
                        else
                            row_reg <= row_reg + AW'(1);
                    end
                end
                S_CLOSE:
                begin
                    if (do_step_reg)
                    begin
                        do_step_reg <= 1'b0;
                        if (clen_reg < MaxLen)
                        begin
                            // Row zero of the old column equals the old length.
                            clen_reg  <= clen_reg + LW'(1);
                            diag_reg  <= DW'(clen_reg);
                            row_reg   <= '0;
                            rd_ok_reg <= 1'b0;
                            state_reg <= S_STEP;
                        end
                        else
                            covf_reg <= 1'b1;
                    end
                    else if (item_reg.end_of_string || item_reg.end_of_list)
                    begin
                        // Result needs the last cell; read it here.
                        if (!rd_ok_reg)
                        begin
                            row_reg   <= (tlen_reg == '0) ? AW'(0) : AW'(tlen_reg - LW'(1));
                            rd_ok_reg <= 1'b1;
                        end
                        else if (!out_full)
                        begin
                            rd_ok_reg <= 1'b0;
                            state_reg <= S_IDLE;
                            copen_reg <= 1'b0;
                            option_index <= ccount_reg;
                            distance     <= sat6(tlen_reg == '0 ? diag_reg : col_rd_reg);
                            truncated    <= tovf_reg || covf_reg;
                            last         <= item_reg.end_of_list;
                            if (!bvalid_reg
                                || (tlen_reg == '0 ? diag_reg : col_rd_reg) < bdist_reg)
                            begin
                                is_new_best   <= 1'b1;
                                best_index    <= ccount_reg;
                                best_distance <= sat6(tlen_reg == '0 ? diag_reg : col_rd_reg);
                                bidx_reg      <= ccount_reg;
                                bdist_reg     <= (tlen_reg == '0) ? diag_reg : col_rd_reg;
                                bvalid_reg    <= 1'b1;
                            end
                            else
                            begin
                                is_new_best   <= 1'b0;
                                best_index    <= bidx_reg;
                                best_distance <= sat6(bdist_reg);
                            end
                            if (item_reg.end_of_list)
                            begin
                                ccount_reg <= '0;
                                bidx_reg   <= '0;
                                bdist_reg  <= '0;
                                bvalid_reg <= 1'b0;
                            end
                            else if (ccount_reg != IndexMax)
                                ccount_reg <= ccount_reg + 16'd1;
                        end
                    end
                    else
                    begin
                        rd_ok_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // Column zero: diag for an empty target is row zero of the column.
            if (state_reg == S_CLOSE && !do_step_reg && !rd_ok_reg)
                diag_reg <= (tlen_reg == '0) ? DW'(clen_reg) : diag_reg;
        end
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE) else $error("pop outside idle");
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tlen_reg <= MaxLen && clen_reg <= MaxLen) else $error("length overflow");
    a_best_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_new_best |-> best_index == option_index
        && best_distance == distance) else $error("new best does not match result");
`endif
endmodule

>>> rtl/core/closest_match_edit_distance.sv
// Top level of the closest-match edit distance block.
// Depends on cmed_pkg, cmed_front, cmed_queue and cmed_engine.
`timescale 1ns / 1ps
// Streams a target string, then candidate strings, one byte per transfer, and
// returns one result per closed candidate with its Levenshtein distance and
// the running best (first wins ties). Each candidate byte walks down the stored
// DP column, one cell per cycle; opening a candidate first resets the column.
// A two-entry queue lets input transfers continue while the engine is busy.
module closest_match_edit_distance #(
    parameter int MAX_LEN = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  char_code,
    input  logic        has_char,
    input  logic        end_of_string,
    input  logic        end_of_list,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] option_index,
    output logic [5:0]  distance,
    output logic [15:0] best_index,
    output logic [5:0]  best_distance,
    output logic        is_new_best,
    output logic        truncated,
    output logic        last
);
    import cmed_pkg::*;

    cmed_item_t push_item, pop_item;
    logic       push, full, pop, empty;

    cmed_front u_front (
        .valid_in(in_valid), .stall_in(in_stall), .operation(operation),
        .char_code(char_code), .has_char(has_char), .end_of_string(end_of_string),
        .end_of_list(end_of_list), .q_full(full), .q_push(push), .q_item(push_item)
    );

    cmed_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item), .full(full),
        .pop(pop), .empty(empty), .pop_item(pop_item)
    );

    cmed_engine #(.MAX_LEN(MAX_LEN)) u_engine (
        .clk(clk), .rst_n(rst_n), .q_empty(empty), .q_item(pop_item), .q_pop(pop),
        .out_valid(out_valid), .out_stall(out_stall), .option_index(option_index),
        .distance(distance), .best_index(best_index), .best_distance(best_distance),
        .is_new_best(is_new_best), .truncated(truncated), .last(last)
    );
endmodule

>>> bench/match_checker.sv
// Watches both channels of the closest-match block, predicts each result and compares.
// Depends on the block's port widths only; MAX_LEN must match the instance.
`timescale 1ns / 1ps
module match_checker #(
    parameter int MAX_LEN = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  char_code,
    input  logic        has_char,
    input  logic        end_of_string,
    input  logic        end_of_list,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] option_index,
    input  logic [5:0]  distance,
    input  logic [15:0] best_index,
    input  logic [5:0]  best_distance,
    input  logic        is_new_best,
    input  logic        truncated,
    input  logic        last,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] option_index;
        logic [5:0]  distance;
        logic [15:0] best_index;
        logic [5:0]  best_distance;
        logic        is_new_best;
        logic        truncated;
        logic        last;
    } match_result_t;

    match_result_t expected_matches[$];

    // Shadow copy of the block's search state.
    logic [7:0]  tgt [MAX_LEN];
    int          tgt_len;
    bit          tgt_closed;
    int          col [MAX_LEN + 1];
    int          cand_len;
    logic [15:0] cand_idx;
    logic [15:0] best_idx;
    int          best_dist;
    bit          best_ok;
    bit          tgt_over;
    bit          cand_over;
    bit          cand_open;

    function automatic logic [5:0] clamp6(input int v);
        return (v > 63) ? 6'd63 : v[5:0];
    endfunction

    // Advances the edit distance model by one accepted transfer.
    task automatic predict_match(input logic op, input logic [7:0] ch, input logic has,
                                 input logic eos, input logic eol);
        int diag;
        int left;
        int m;
        int cand_dist;
        bit better;
        match_result_t r;
        if (!op) begin
            if (tgt_closed) begin
                tgt_len = 0;
                tgt_over = 0;
                tgt_closed = 0;
                cand_open = 0;
                cand_idx = 0;
                best_idx = 0;
                best_dist = 0;
                best_ok = 0;
            end
            if (has) begin
                if (tgt_len < MAX_LEN)
                begin
                    tgt[tgt_len] = ch;
                    tgt_len++;
                end
                else
                    tgt_over = 1;
            end
            if (eos)
                tgt_closed = 1;
            return;
        end
        tgt_closed = 1;
        if (!cand_open) begin
            for (int i = 0; i <= tgt_len; i++)
                col[i] = i;
            cand_len = 0;
            cand_over = 0;
            cand_open = 1;
        end
        if (has) begin
            if (cand_len < MAX_LEN) begin
                diag = col[0];
                cand_len++;
                col[0] = cand_len;
                for (int i = 1; i <= tgt_len; i++) begin
                    left = col[i];
                    if (tgt[i - 1] == ch)
                        col[i] = diag;
                    else
                    begin
                        m = (left < col[i - 1]) ? left : col[i - 1];
                        m = (m < diag) ? m : diag;
                        col[i] = m + 1;
                    end
                    diag = left;
                end
            end
            else
                cand_over = 1;
        end
        if (!eos && !eol)
            return;
        cand_dist = col[tgt_len];
        better = !best_ok || cand_dist < best_dist;
        if (better) begin
            best_ok = 1;
            best_dist = cand_dist;
            best_idx = cand_idx;
        end
        r.option_index = cand_idx;
        r.distance = clamp6(cand_dist);
        r.best_index = best_idx;
        r.best_distance = clamp6(best_dist);
        r.is_new_best = better;
        r.truncated = tgt_over || cand_over;
        r.last = eol;
        expected_matches.push_back(r);
        if (cand_idx != 16'hFFFF)
            cand_idx++;
        cand_open = 0;
        if (eol) begin
            cand_idx = 0;
            best_idx = 0;
            best_dist = 0;
            best_ok = 0;
        end
    endtask

    // Prediction on input transfers, comparison on output transfers.
    always @(posedge clk or negedge rst_n)
    begin
        match_result_t exp_r;
        if (!rst_n) begin
            tgt_len = 0;
            tgt_closed = 1;
            cand_len = 0;
            cand_idx = 0;
            best_idx = 0;
            best_dist = 0;
            best_ok = 0;
            tgt_over = 0;
            cand_over = 0;
            cand_open = 0;
            fail_count = 0;
            expected_matches.delete();
        end
        else
        begin
            if (out_valid && !out_stall) begin
                if (expected_matches.size() == 0) begin
                    $error("unexpected result transfer, option_index %0d", option_index);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_matches.pop_front();
                    if (option_index !== exp_r.option_index) begin
                        $error("option_index expected %0d got %0d",
                               exp_r.option_index, option_index);
                        fail_count++;
                    end
                    if (distance !== exp_r.distance) begin
                        $error("distance expected %0d got %0d", exp_r.distance, distance);
                        fail_count++;
                    end
                    if (best_index !== exp_r.best_index) begin
                        $error("best_index expected %0d got %0d",
                               exp_r.best_index, best_index);
                        fail_count++;
                    end
                    if (best_distance !== exp_r.best_distance) begin
                        $error("best_distance expected %0d got %0d",
                               exp_r.best_distance, best_distance);
                        fail_count++;
                    end
                    if (is_new_best !== exp_r.is_new_best) begin
                        $error("is_new_best expected %0d got %0d",
                               exp_r.is_new_best, is_new_best);
                        fail_count++;
                    end
                    if (truncated !== exp_r.truncated) begin
                        $error("truncated expected %0d got %0d", exp_r.truncated, truncated);
                        fail_count++;
                    end
                    if (last !== exp_r.last) begin
                        $error("last expected %0d got %0d", exp_r.last, last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_match(operation, char_code, has_char, end_of_string, end_of_list);
        end
        pending = expected_matches.size();
    end

endmodule

>>> bench/testbench.sv
// Top of the closest-match bench: clock, reset, stimulus and the verdict.
// Depends on closest_match_edit_distance and match_checker.
`timescale 1ns / 1ps
module testbench;

    localparam int MaxLen = 32;
    localparam int CycleLimit = 2000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [7:0]  char_code;
    logic        has_char;
    logic        end_of_string;
    logic        end_of_list;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] option_index;
    logic [5:0]  distance;
    logic [15:0] best_index;
    logic [5:0]  best_distance;
    logic        is_new_best;
    logic        truncated;
    logic        last;
    int          fail_count;
    int          pending;
    int          cycle_count;
    int          sent_count;
    bit          long_hold;
    logic [7:0]  tgt_text [$];

    closest_match_edit_distance #(.MAX_LEN(MaxLen)) uut (.*);
    match_checker #(.MAX_LEN(MaxLen)) watch (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Cycle counter that ends a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Receiver stall pattern, with one long hold-off on request.
    initial
    begin
        int mode;
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold) begin
                out_stall <= 1;
                repeat (600) @(posedge clk);
                long_hold = 0;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 40))
            begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // One input transfer; keeps valid high between back-to-back items.
    task automatic send_item(input logic op, input logic [7:0] ch, input logic has,
                             input logic eos, input logic eol);
        in_valid <= 1;
        operation <= op;
        char_code <= ch;
        has_char <= has;
        end_of_string <= eos;
        end_of_list <= eol;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic go_idle(input int n);
        in_valid <= 0;
        repeat (n) @(posedge clk);
    endtask

    // Random gaps between bursts.
    task automatic maybe_gap();
        if ($urandom_range(0, 7) == 0)
            go_idle($urandom_range(1, 12));
    endtask

    task automatic send_target(input int len, input bit mark_end);
        logic [7:0] c;
        tgt_text.delete();
        if (len == 0) begin
            send_item(0, 8'($urandom), 0, mark_end, 1'($urandom));
            return;
        end
        for (int i = 0; i < len; i++) begin
            c = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                            : 8'h61 + 8'($urandom_range(0, 3));
            tgt_text.push_back(c);
            send_item(0, c, 1, mark_end && i == len - 1, 1'($urandom));
            maybe_gap();
        end
    endtask

    // Candidate usually a mutation of the target, sometimes noise.
    task automatic send_candidate(input int len, input bit eol, input bit close_by_eol);
        logic [7:0] c;
        bit fin;
        if (len == 0) begin
            send_item(1, 8'($urandom), 0, !close_by_eol, eol);
            return;
        end
        for (int i = 0; i < len; i++) begin
            if (i < tgt_text.size() && $urandom_range(0, 3) != 0)
                c = tgt_text[i];
            else
                c = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                : 8'h61 + 8'($urandom_range(0, 3));
            if ($urandom_range(0, 15) == 0)
                c = c ^ 8'h20;
            fin = (i == len - 1);
            send_item(1, c, 1, fin && !close_by_eol, fin && eol);
            maybe_gap();
        end
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        int n_cands;
        int tl;
        cycle_count = 0;
        sent_count = 0;
        long_hold = 0;
        rst_n = 0;
        in_valid = 0;
        operation = 0;
        char_code = 0;
        has_char = 0;
        end_of_string = 0;
        end_of_list = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: equal, case-differing, ties, empty strings, overlong strings.
        send_item(0, 8'h41, 1, 0, 1);
        send_item(0, 8'hFF, 1, 0, 0);
        send_item(0, 8'h00, 1, 1, 0);
        tgt_text = '{8'h41, 8'hFF, 8'h00};
        send_item(1, 8'h41, 1, 0, 0);
        send_item(1, 8'hFF, 1, 0, 0);
        send_item(1, 8'h00, 1, 1, 0);
        send_item(1, 8'h61, 1, 1, 0);
        send_item(1, 8'h00, 0, 1, 0);
        send_item(1, 8'h00, 0, 1, 0);
        send_item(1, 8'h41, 1, 0, 1);
        // Candidate before the target closes, then an empty target.
        send_item(0, 8'h7A, 1, 0, 0);
        send_item(1, 8'h7A, 1, 1, 1);
        send_item(0, 8'h00, 0, 1, 0);
        send_item(1, 8'h00, 0, 0, 1);
        wait_drained();
        send_target(MaxLen + 3, 1);
        send_candidate(MaxLen + 2, 0, 0);
        send_candidate(2, 1, 1);

        // Long receiver hold while items keep coming.
        long_hold = 1;
        send_target(8, 1);
        send_candidate(3, 0, 0);
        send_candidate(1, 0, 0);
        send_candidate(5, 0, 0);
        send_candidate(0, 1, 0);
        wait_drained();

        // Random lists, mostly short strings.
        while (sent_count < 820)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom));
            tl = ($urandom_range(0, 15) == 0) ? $urandom_range(MaxLen - 2, MaxLen + 3)
                                              : $urandom_range(0, 6);
            send_target(tl, $urandom_range(0, 4) != 0);
            n_cands = $urandom_range(1, 6);
            for (int k = 0; k < n_cands; k++) begin
                tl = ($urandom_range(0, 20) == 0) ? $urandom_range(MaxLen - 1, MaxLen + 2)
                                                  : $urandom_range(0, 7);
                send_candidate(tl, k == n_cands - 1 && $urandom_range(0, 3) != 0,
                               $urandom_range(0, 5) == 0);
                maybe_gap();
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        wait_drained();
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> files.f
rtl/core/cmed_pkg.sv
rtl/core/cmed_queue.sv
rtl/core/cmed_front.sv
rtl/core/cmed_engine.sv
rtl/core/closest_match_edit_distance.sv
bench/match_checker.sv
bench/testbench.sv
